// ===== rtl/core/csvd_pkg.sv =====
package csvd_pkg;

	localparam int LEN_BITS   = 32;
	localparam int QDEPTH     = 4;
	localparam int QPTR_BITS  = $clog2(QDEPTH);
	localparam int CFG_BITS   = 32;
	localparam int VAL_BITS   = 64;

	localparam logic [7:0] PFX_U16 = 8'hFD;
	localparam logic [7:0] PFX_U32 = 8'hFE;
	localparam logic [7:0] PFX_U64 = 8'hFF;

	localparam logic [1:0] REG_STRING_MODE = 2'd0;
	localparam logic [1:0] REG_BIG_ENDIAN  = 2'd1;
	localparam logic [1:0] REG_MAX_LEN     = 2'd2;

	localparam logic [CFG_BITS-1:0] MAX_LEN_RESET = 32'h00FF_FFFF;

	typedef enum logic [1:0] {
		PH_PREFIX  = 2'd0,
		PH_BODY    = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_VALUE   = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_TRUNC   = 2'd2,
		KIND_LONG    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic [VAL_BITS-1:0]  value;
		logic [7:0]           payload;
		logic                 end_of_item;
		logic                 trunc_after;
	} entry_t;

endpackage

// ===== rtl/core/csvd_front.sv =====
module csvd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [1:0]                    cfg_index,
	input  logic [csvd_pkg::CFG_BITS-1:0] cfg_data,
	input  logic                          push,
	input  logic [7:0]                    data_byte,
	input  logic                          last_in_buffer,
	input  logic                          q_full,
	output logic                          q_push,
	output csvd_pkg::entry_t              q_entry
);
	import csvd_pkg::*;

	logic                string_mode_q;
	logic                big_endian_q;
	logic [CFG_BITS-1:0] max_len_q;

	phase_t              phase_q, phase_d;
	logic [3:0]          left_q, left_d;
	logic [3:0]          width_q, width_d;
	logic [VAL_BITS-1:0] acc_q, acc_d;
	logic [LEN_BITS-1:0] pay_left_q, pay_left_d;

	logic                accept;
	logic                emit;
	logic [VAL_BITS-1:0] fin_v;
	logic                fin_en;
	logic                over;
	logic [2:0]          idx;
	logic [3:0]          left_dec;
	logic [VAL_BITS-1:0] acc_body;

	assign accept = push && !q_full;
	assign q_push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			string_mode_q <= 1'b1;
			big_endian_q  <= 1'b1;
			max_len_q     <= MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_STRING_MODE: string_mode_q <= cfg_data[0];
				REG_BIG_ENDIAN:  big_endian_q  <= cfg_data[0];
				REG_MAX_LEN:     max_len_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_PREFIX;
			left_q     <= '0;
			width_q    <= '0;
			acc_q      <= '0;
			pay_left_q <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			left_q     <= left_d;
			width_q    <= width_d;
			acc_q      <= acc_d;
			pay_left_q <= pay_left_d;
		end
	end

	assign idx      = 3'(width_q - left_q);
	assign left_dec = left_q - 4'd1;
	assign acc_body = big_endian_q ? {acc_q[VAL_BITS-9:0], data_byte}
	                               : acc_q | ({{(VAL_BITS-8){1'b0}}, data_byte} << {idx, 3'b000});

	always_comb begin
		phase_d    = PH_PREFIX;
		left_d     = '0;
		width_d    = '0;
		acc_d      = '0;
		pay_left_d = '0;
		emit       = 1'b0;
		q_entry    = '{kind: KIND_VALUE, value: '0, payload: 8'd0,
		               end_of_item: 1'b0, trunc_after: 1'b0};
		fin_en     = 1'b0;
		fin_v      = '0;

		case (phase_q)
			PH_PAYLOAD: begin
				emit                = 1'b1;
				q_entry.kind        = KIND_PAYLOAD;
				q_entry.payload     = data_byte;
				q_entry.end_of_item = (pay_left_q <= LEN_BITS'(1));
				if (pay_left_q > LEN_BITS'(1)) begin
					if (last_in_buffer) begin
						q_entry.trunc_after = 1'b1;
					end else begin
						phase_d    = PH_PAYLOAD;
						pay_left_d = pay_left_q - LEN_BITS'(1);
					end
				end
			end
			PH_BODY: begin
				if (left_dec == 4'd0) begin
					fin_en = 1'b1;
					fin_v  = acc_body;
				end else if (last_in_buffer) begin
					emit                = 1'b1;
					q_entry.kind        = KIND_TRUNC;
					q_entry.end_of_item = 1'b1;
				end else begin
					phase_d = PH_BODY;
					left_d  = left_dec;
					width_d = width_q;
					acc_d   = acc_body;
				end
			end
			default: begin
				if (data_byte < PFX_U16) begin
					fin_en = 1'b1;
					fin_v  = {{(VAL_BITS-8){1'b0}}, data_byte};
				end else if (last_in_buffer) begin
					emit                = 1'b1;
					q_entry.kind        = KIND_TRUNC;
					q_entry.end_of_item = 1'b1;
				end else begin
					phase_d = PH_BODY;
					width_d = (data_byte == PFX_U16) ? 4'd2 :
					          (data_byte == PFX_U32) ? 4'd4 : 4'd8;
					left_d  = width_d;
				end
			end
		endcase

		over = (fin_v > {{(VAL_BITS-CFG_BITS){1'b0}}, max_len_q})
		    || (((fin_v >> (LEN_BITS-1)) >> 1) != '0);

		// varint complete
		if (fin_en) begin
			emit                = 1'b1;
			q_entry.end_of_item = 1'b1;
			q_entry.value       = fin_v;
			if (string_mode_q) begin
				if (over) begin
					q_entry.kind = KIND_LONG;
				end else if (fin_v != '0) begin
					q_entry.end_of_item = 1'b0;
					if (last_in_buffer) begin
						q_entry.trunc_after = 1'b1;
					end else begin
						phase_d    = PH_PAYLOAD;
						pay_left_d = fin_v[LEN_BITS-1:0];
					end
				end
			end
		end
	end

	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> left_q != 4'd0 && left_q <= width_q)
		else $error("varint body count out of range");

	a_trunc_single: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && q_entry.kind == KIND_TRUNC |-> !q_entry.trunc_after)
		else $error("truncation word carries a second truncation");

endmodule

// ===== rtl/core/csvd_queue.sv =====
module csvd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             pop,
	output logic             full,
	output logic             empty,
	input  csvd_pkg::entry_t wr_entry,
	output csvd_pkg::entry_t rd_entry
);
	import csvd_pkg::*;

	entry_t               mem_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full     = (count_q == (QPTR_BITS+1)'(QDEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			count_q <= count_q + (QPTR_BITS+1)'(do_push) - (QPTR_BITS+1)'(do_pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_BITS+1)'(QDEPTH))
		else $error("queue count overflow");

endmodule

// ===== rtl/core/csvd_back.sv =====
module csvd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  csvd_pkg::entry_t q_head,
	output logic             q_pop,
	input  logic             pop,
	output logic             empty,
	output logic [1:0]       kind,
	output logic [63:0]      value,
	output logic [7:0]       payload,
	output logic             end_of_item
);
	import csvd_pkg::*;

	logic   out_valid_q;
	entry_t out_q;
	logic   second_q;
	logic   take;
	logic   done_part;

	assign empty     = !out_valid_q;
	assign done_part = second_q || !out_q.trunc_after;
	assign take      = !q_empty && (!out_valid_q || (pop && done_part));
	assign q_pop     = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (out_valid_q && pop && !done_part) begin
			second_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b1;
			second_q    <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= q_head;
		end
	end

	// second word of a pair is always a truncation
	always_comb begin
		if (second_q) begin
			kind        = KIND_TRUNC;
			value       = '0;
			payload     = 8'd0;
			end_of_item = 1'b1;
		end else begin
			kind        = out_q.kind;
			value       = out_q.value;
			payload     = out_q.payload;
			end_of_item = out_q.end_of_item;
		end
	end

	a_second_valid: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> out_valid_q && out_q.trunc_after)
		else $error("second word without a pending pair");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && pop && !second_q && out_q.trunc_after |=> second_q)
		else $error("truncation word skipped");

endmodule

// ===== rtl/core/compactsize_varstring_deframer.sv =====
// Decodes a byte stream of compact-size varints, one byte per cycle while not full. In string
// mode each varint is a length word followed by its payload bytes; otherwise each varint is one
// value word. A byte yields zero, one or two result words; when it yields two (a word followed
// by a truncation word) the output side needs two pops for it, and a four-entry queue between
// the byte decoder and the output register absorbs such bursts. A result word is written into
// the queue and then moved into the output register before it shows on the output ports.
// Configuration must only be written while the block holds no pending byte.
module compactsize_varstring_deframer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [1:0]                    cfg_index,
	input  logic [csvd_pkg::CFG_BITS-1:0] cfg_data,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    data_byte,
	input  logic                          last_in_buffer,
	output logic                          empty,
	input  logic                          pop,
	output logic [1:0]                    kind,
	output logic [63:0]                   value,
	output logic [7:0]                    payload,
	output logic                          end_of_item
);
	import csvd_pkg::*;

	entry_t wr_entry;
	entry_t rd_entry;
	logic   f_push;
	logic   b_pop;
	logic   q_full;
	logic   q_empty;

	assign full = q_full;

	csvd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.data_byte      (data_byte),
		.last_in_buffer (last_in_buffer),
		.q_full         (q_full),
		.q_push         (f_push),
		.q_entry        (wr_entry)
	);

	csvd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_push),
		.pop      (b_pop),
		.full     (q_full),
		.empty    (q_empty),
		.wr_entry (wr_entry),
		.rd_entry (rd_entry)
	);

	csvd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_head      (rd_entry),
		.q_pop       (b_pop),
		.pop         (pop),
		.empty       (empty),
		.kind        (kind),
		.value       (value),
		.payload     (payload),
		.end_of_item (end_of_item)
	);

endmodule
